[rtl/lufs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package lufs_pkg;

  localparam int MAX_ORDER = 16;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int QUO_W     = DATA_W + FRAC_W;

  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] ONE_Q   = DATA_W'(1) << FRAC_W;

  localparam logic [2:0] FN_LOAD_A = 3'd0;
  localparam logic [2:0] FN_LOAD_B = 3'd1;
  localparam logic [2:0] FN_FACTOR = 3'd2;
  localparam logic [2:0] FN_SOLVE  = 3'd3;
  localparam logic [2:0] FN_INVCOL = 3'd4;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_ZERO_PIVOT   = 2'd1;
  localparam logic [1:0] ST_NOT_FACTORED = 2'd2;
  localparam logic [1:0] ST_SAT          = 2'd3;

  typedef enum logic [2:0] {
    MW_IN, MW_RDATA, MW_TMP, MW_QUOT, MW_SUB
  } mwsrc_t;

  typedef enum logic [1:0] {
    WV_INIT, WV_ACC, WV_QUOT
  } wvsrc_t;

  typedef enum logic [5:0] {
    S_IDLE, S_F_INIT, S_F_PS_RD, S_F_PS_CMP, S_F_PS_CHK,
    S_F_SW_RD1, S_F_SW_RD2, S_F_SW_W1, S_F_SW_W2,
    S_F_PV_RD, S_F_PV_LD, S_F_L_RD, S_F_L_DIV, S_F_L_WAIT,
    S_F_K_RDU, S_F_K_MUL, S_F_K_RND, S_F_K_SUB, S_F_NEXT,
    S_F_DONE, S_F_ZERO, S_S_ERR, S_S_INIT, S_S_WI,
    S_S_FW_ROW, S_S_MRD, S_S_MMUL, S_S_MRND, S_S_MSUB, S_S_FW_ST,
    S_S_BK_ROW, S_S_BK_DRD, S_S_BK_DIV, S_S_BK_WAIT, S_S_EMIT
  } state_t;

  typedef struct packed {
    logic              mem_rd;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_wr;
    logic [ADDR_W-1:0] wr_addr;
    mwsrc_t            wr_src;
    logic              best_en;
    logic              best_first;
    logic [IDX_W-1:0]  best_row;
    logic              tmp_ld;
    logic              piv_ld;
    logic              div_start;
    logic              div_num_acc;
    logic              div_den_rd;
    logic              lval_ld;
    logic              mul_en;
    logic              mul_by_wv;
    logic              rnd_en;
    logic              acc_ld_wv;
    logic              acc_ld_sub;
    logic              sub_from_acc;
    logic              wv_wr;
    logic [IDX_W-1:0]  wv_wr_idx;
    wvsrc_t            wv_src;
    logic [IDX_W-1:0]  wv_idx;
    logic              perm_init;
    logic              perm_swap;
    logic [IDX_W-1:0]  perm_i;
    logic              rhs_wr;
    logic              col_cap;
    logic              unit;
    logic              sat_clr;
    logic              out_load;
    logic              out_zero;
    logic [IDX_W-1:0]  out_row;
    logic [1:0]        out_status;
    logic              out_last;
  } cmd_t;

  typedef struct packed {
    logic             out_free;
    logic             div_done;
    logic             sat;
    logic             best_zero;
    logic [IDX_W-1:0] piv_row;
  } stat_t;

  function automatic logic [ADDR_W-1:0] maddr(input logic [IDX_W-1:0] r,
                                              input logic [IDX_W-1:0] c);
    maddr = {r, c};
  endfunction

endpackage
`default_nettype wire

[rtl/lufs_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module lufs_div
  import lufs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [DATA_W-1:0] num,
  input  wire logic signed [DATA_W-1:0] den,
  output logic                          done,
  output logic signed [DATA_W-1:0]      quot,
  output logic                          sat
);

  localparam logic [5:0] ITER = 6'(QUO_W);

  logic              busy_r, busy_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic              neg_r, neg_nxt;
  logic              zero_r, zero_nxt;
  logic              done_r, done_nxt;
  logic signed [DATA_W-1:0] q_r, q_nxt;
  logic              sat_r, sat_nxt;

  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   trial;
  logic [DATA_W-1:0] num_mag, den_mag;

  always_comb begin
    num_mag = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
    den_mag = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
    rem_sh  = {rem_r, quo_r[QUO_W-1]};
    trial   = rem_sh - {1'b0, dvs_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    sat_nxt  = sat_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ITER;
      rem_nxt  = '0;
      quo_nxt  = {num_mag, {FRAC_W{1'b0}}};
      dvs_nxt  = den_mag;
      neg_nxt  = num[DATA_W-1] ^ den[DATA_W-1];
      zero_nxt = (den == '0);
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 6'd1;
        if (!trial[DATA_W]) begin
          rem_nxt = trial[DATA_W-1:0];
          quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DATA_W-1:0];
          quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
        end
      end else begin
        // saturate the magnitude and apply the sign; a zero divisor gives zero
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        sat_nxt  = 1'b0;
        if (zero_r) begin
          q_nxt = '0;
        end else if (neg_r) begin
          if (quo_r > QUO_W'({1'b0, VAL_MIN})) begin
            q_nxt   = VAL_MIN;
            sat_nxt = 1'b1;
          end else begin
            q_nxt = DATA_W'(-quo_r[DATA_W-1:0]);
          end
        end else begin
          if (quo_r > QUO_W'(VAL_MAX)) begin
            q_nxt   = VAL_MAX;
            sat_nxt = 1'b1;
          end else begin
            q_nxt = quo_r[DATA_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    q_r    <= q_nxt;
    sat_r  <= sat_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign sat  = sat_r;

endmodule
`default_nettype wire

[rtl/lufs_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module lufs_dp
  import lufs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cmd_t                     cmd,
  output stat_t                         stat,
  input  wire logic [IDX_W-1:0]         in_row,
  input  wire logic [IDX_W-1:0]         in_col,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_value,
  output logic [IDX_W-1:0]              out_row,
  output logic [1:0]                    out_status,
  output logic                          out_last
);

  localparam int DEPTH = MAX_ORDER * MAX_ORDER;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_r;
  logic signed [DATA_W-1:0] rhs_r [MAX_ORDER];
  logic signed [DATA_W-1:0] wv_r [MAX_ORDER];
  logic [IDX_W-1:0]         perm_r [MAX_ORDER];
  logic [IDX_W-1:0]         ucol_r;

  logic signed [DATA_W-1:0] tmp_r, piv_r, lval_r, mq_r, acc_r;
  logic signed [2*DATA_W-1:0] prod_r;
  logic [DATA_W:0]          best_r;
  logic [IDX_W-1:0]         pivrow_r;
  logic                     sat_r;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic [IDX_W-1:0]         out_row_r;
  logic [1:0]               out_status_r;
  logic                     out_last_r;

  logic                     div_done, div_sat;
  logic signed [DATA_W-1:0] div_q, div_num, div_den;

  logic [DATA_W:0]          mag;
  logic signed [DATA_W-1:0] wv_rd, mul_b, suba, sub_res, mq_val, wdata, wv_init, wv_wdata;
  logic signed [DATA_W:0]   diff;
  logic signed [2*DATA_W-1:0] shifted;
  logic                     sub_sat, mq_sat, sub_used, out_free;
  logic [ADDR_W-1:0]        waddr;
  logic [IDX_W-1:0]         psrc;

  always_comb begin
    mag     = rdata_r[DATA_W-1] ? ((DATA_W+1)'(0) - {1'b1, rdata_r}) : {1'b0, rdata_r};
    wv_rd   = wv_r[cmd.wv_idx];
    mul_b   = cmd.mul_by_wv ? wv_rd : lval_r;
    suba    = cmd.sub_from_acc ? acc_r : rdata_r;
    diff    = {suba[DATA_W-1], suba} - {mq_r[DATA_W-1], mq_r};
    sub_sat = diff[DATA_W] != diff[DATA_W-1];
    sub_res = !sub_sat ? diff[DATA_W-1:0] : (diff[DATA_W] ? VAL_MIN : VAL_MAX);
    // floor rounding of a product is an arithmetic shift
    shifted = prod_r >>> FRAC_W;
    mq_sat  = 1'b0;
    mq_val  = shifted[DATA_W-1:0];
    if (shifted > (2*DATA_W)'(VAL_MAX)) begin
      mq_val = VAL_MAX;
      mq_sat = 1'b1;
    end else if (shifted < (2*DATA_W)'(VAL_MIN)) begin
      mq_val = VAL_MIN;
      mq_sat = 1'b1;
    end
    sub_used = (cmd.mem_wr && cmd.wr_src == MW_SUB) || cmd.acc_ld_sub;
    psrc     = perm_r[cmd.perm_i];
    wv_init  = cmd.unit ? ((psrc == ucol_r) ? ONE_Q : '0) : rhs_r[psrc];
    case (cmd.wv_src)
      WV_INIT: wv_wdata = wv_init;
      WV_ACC:  wv_wdata = acc_r;
      WV_QUOT: wv_wdata = div_q;
      default: wv_wdata = acc_r;
    endcase
    case (cmd.wr_src)
      MW_IN:    wdata = in_value;
      MW_RDATA: wdata = rdata_r;
      MW_TMP:   wdata = tmp_r;
      MW_QUOT:  wdata = div_q;
      MW_SUB:   wdata = sub_res;
      default:  wdata = rdata_r;
    endcase
    waddr    = (cmd.wr_src == MW_IN) ? maddr(in_row, in_col) : cmd.wr_addr;
    div_num  = cmd.div_num_acc ? acc_r : rdata_r;
    div_den  = cmd.div_den_rd ? rdata_r : piv_r;
    out_free = !out_valid_r || !out_stall;
  end

  lufs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q),
    .sat   (div_sat)
  );

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[waddr] <= wdata;
    if (cmd.mem_rd) rdata_r <= mem[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.rhs_wr) rhs_r[in_row] <= in_value;
    if (cmd.col_cap) ucol_r <= in_col;
    if (cmd.wv_wr) wv_r[cmd.wv_wr_idx] <= wv_wdata;
    if (cmd.perm_init) begin
      for (int e = 0; e < MAX_ORDER; e++) perm_r[e] <= IDX_W'(e);
    end else if (cmd.perm_swap) begin
      perm_r[cmd.perm_i] <= perm_r[pivrow_r];
      perm_r[pivrow_r]   <= perm_r[cmd.perm_i];
    end
    if (cmd.tmp_ld) tmp_r <= rdata_r;
    if (cmd.piv_ld) piv_r <= rdata_r;
    if (cmd.lval_ld) lval_r <= div_q;
    if (cmd.mul_en) prod_r <= rdata_r * mul_b;
    if (cmd.rnd_en) mq_r <= mq_val;
    if (cmd.acc_ld_wv) acc_r <= wv_rd;
    else if (cmd.acc_ld_sub) acc_r <= sub_res;
    if (cmd.best_en && (cmd.best_first || best_r < mag)) begin
      best_r   <= mag;
      pivrow_r <= cmd.best_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sat_clr) begin
        sat_r <= 1'b0;
      end else if ((cmd.rnd_en && mq_sat) || (sub_used && sub_sat) ||
                   (div_done && div_sat)) begin
        sat_r <= 1'b1;
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_value_r  <= cmd.out_zero ? '0 : wv_rd;
      out_row_r    <= cmd.out_row;
      out_status_r <= cmd.out_status;
      out_last_r   <= cmd.out_last;
    end
  end

  always_comb begin
    stat.out_free  = out_free;
    stat.div_done  = div_done;
    stat.sat       = sat_r;
    stat.best_zero = (best_r == '0);
    stat.piv_row   = pivrow_r;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_row    = out_row_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

[rtl/lufs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module lufs_ctrl
  import lufs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_func,
  input  wire logic       cfg_wr_en,
  input  wire logic [4:0] cfg_wr_data,
  input  wire stat_t      stat,
  output cmd_t            cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, n_r, n_nxt;
  logic             factored_r, factored_nxt;
  logic             unit_r, unit_nxt;
  logic             back_r, back_nxt;
  logic             in_acc;
  logic [IDX_W-1:0] i4, j4, k4;
  logic [CNT_W-1:0] i1, j1, k1;

  always_comb begin
    in_acc = in_valid && !in_stall;
    i4 = i_r[IDX_W-1:0];
    j4 = j_r[IDX_W-1:0];
    k4 = k_r[IDX_W-1:0];
    i1 = i_r + CNT_W'(1);
    j1 = j_r + CNT_W'(1);
    k1 = k_r + CNT_W'(1);
  end

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    n_nxt        = n_r;
    factored_nxt = factored_r;
    unit_nxt     = unit_r;
    back_nxt     = back_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_func)
            FN_LOAD_A: factored_nxt = 1'b0;
            FN_FACTOR: state_nxt = S_F_INIT;
            FN_SOLVE, FN_INVCOL: begin
              unit_nxt  = (in_func == FN_INVCOL);
              state_nxt = factored_r ? S_S_INIT : S_S_ERR;
            end
            default: ;
          endcase
        end
      end
      S_F_INIT: begin
        factored_nxt = 1'b0;
        i_nxt = '0;
        j_nxt = '0;
        state_nxt = S_F_PS_RD;
      end
      S_F_PS_RD: state_nxt = S_F_PS_CMP;
      S_F_PS_CMP: begin
        if (j1 < n_r) begin
          j_nxt = j1;
          state_nxt = S_F_PS_RD;
        end else begin
          state_nxt = S_F_PS_CHK;
        end
      end
      S_F_PS_CHK: begin
        if (stat.best_zero) begin
          state_nxt = S_F_ZERO;
        end else if (stat.piv_row != i4) begin
          j_nxt = '0;
          state_nxt = S_F_SW_RD1;
        end else begin
          state_nxt = S_F_PV_RD;
        end
      end
      S_F_SW_RD1: state_nxt = S_F_SW_RD2;
      S_F_SW_RD2: state_nxt = S_F_SW_W1;
      S_F_SW_W1:  state_nxt = S_F_SW_W2;
      S_F_SW_W2: begin
        if (j1 < n_r) begin
          j_nxt = j1;
          state_nxt = S_F_SW_RD1;
        end else begin
          state_nxt = S_F_PV_RD;
        end
      end
      S_F_PV_RD: begin
        j_nxt = i1;
        state_nxt = S_F_PV_LD;
      end
      S_F_PV_LD: state_nxt = (j_r < n_r) ? S_F_L_RD : S_F_NEXT;
      S_F_L_RD:  state_nxt = S_F_L_DIV;
      S_F_L_DIV: state_nxt = S_F_L_WAIT;
      S_F_L_WAIT: begin
        if (stat.div_done) begin
          k_nxt = i1;
          state_nxt = S_F_K_RDU;
        end
      end
      S_F_K_RDU: state_nxt = S_F_K_MUL;
      S_F_K_MUL: state_nxt = S_F_K_RND;
      S_F_K_RND: state_nxt = S_F_K_SUB;
      S_F_K_SUB: begin
        if (k1 < n_r) begin
          k_nxt = k1;
          state_nxt = S_F_K_RDU;
        end else if (j1 < n_r) begin
          j_nxt = j1;
          state_nxt = S_F_L_RD;
        end else begin
          state_nxt = S_F_NEXT;
        end
      end
      S_F_NEXT: begin
        if (i1 < n_r) begin
          i_nxt = i1;
          j_nxt = i1;
          state_nxt = S_F_PS_RD;
        end else begin
          state_nxt = S_F_DONE;
        end
      end
      S_F_DONE: begin
        if (stat.out_free) begin
          factored_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_F_ZERO, S_S_ERR: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_S_INIT: begin
        i_nxt = '0;
        state_nxt = S_S_WI;
      end
      S_S_WI: begin
        if (i1 < n_r) begin
          i_nxt = i1;
        end else begin
          i_nxt = '0;
          state_nxt = S_S_FW_ROW;
        end
      end
      S_S_FW_ROW: begin
        j_nxt = '0;
        back_nxt = 1'b0;
        state_nxt = (i_r != '0) ? S_S_MRD : S_S_FW_ST;
      end
      S_S_MRD:  state_nxt = S_S_MMUL;
      S_S_MMUL: state_nxt = S_S_MRND;
      S_S_MRND: state_nxt = S_S_MSUB;
      S_S_MSUB: begin
        if (back_r ? (j1 < n_r) : (j1 < i_r)) begin
          j_nxt = j1;
          state_nxt = S_S_MRD;
        end else begin
          state_nxt = back_r ? S_S_BK_DRD : S_S_FW_ST;
        end
      end
      S_S_FW_ST: begin
        if (i1 < n_r) begin
          i_nxt = i1;
          state_nxt = S_S_FW_ROW;
        end else begin
          i_nxt = n_r - CNT_W'(1);
          state_nxt = S_S_BK_ROW;
        end
      end
      S_S_BK_ROW: begin
        j_nxt = i1;
        back_nxt = 1'b1;
        state_nxt = (i1 < n_r) ? S_S_MRD : S_S_BK_DRD;
      end
      S_S_BK_DRD: state_nxt = S_S_BK_DIV;
      S_S_BK_DIV: state_nxt = S_S_BK_WAIT;
      S_S_BK_WAIT: begin
        if (stat.div_done) begin
          if (i_r == '0) begin
            state_nxt = S_S_EMIT;
          end else begin
            i_nxt = i_r - CNT_W'(1);
            state_nxt = S_S_BK_ROW;
          end
        end
      end
      S_S_EMIT: begin
        if (stat.out_free) begin
          if (i1 == n_r) state_nxt = S_IDLE;
          else i_nxt = i1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // order 0 runs as 1, anything above the maximum as the maximum
    if (cfg_wr_en) begin
      factored_nxt = 1'b0;
      if (cfg_wr_data == '0) n_nxt = CNT_W'(1);
      else if (cfg_wr_data > CNT_W'(MAX_ORDER)) n_nxt = CNT_W'(MAX_ORDER);
      else n_nxt = cfg_wr_data;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.wr_src = MW_RDATA;
    cmd.wv_src = WV_ACC;
    cmd.unit   = unit_r;
    cmd.perm_i = i4;
    in_stall   = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_func)
            FN_LOAD_A: begin
              cmd.mem_wr = 1'b1;
              cmd.wr_src = MW_IN;
            end
            FN_LOAD_B: cmd.rhs_wr = 1'b1;
            FN_INVCOL: cmd.col_cap = 1'b1;
            default: ;
          endcase
        end
      end
      S_F_INIT: begin
        cmd.perm_init = 1'b1;
        cmd.sat_clr   = 1'b1;
      end
      S_F_PS_RD: begin
        cmd.mem_rd  = 1'b1;
        cmd.rd_addr = maddr(j4, i4);
      end
      S_F_PS_CMP: begin
        cmd.best_en    = 1'b1;
        cmd.best_first = (j_r == i_r);
        cmd.best_row   = j4;
      end
      S_F_PS_CHK: begin
        cmd.perm_swap = !stat.best_zero && (stat.piv_row != i4);
      end
      S_F_SW_RD1: begin
        cmd.mem_rd  = 1'b1;
        cmd.rd_addr = maddr(i4, j4);
      end
      S_F_SW_RD2: begin
        cmd.mem_rd  = 1'b1;
        cmd.rd_addr = maddr(stat.piv_row, j4);
        cmd.tmp_ld  = 1'b1;
      end
      S_F_SW_W1: begin
        cmd.mem_wr  = 1'b1;
        cmd.wr_addr = maddr(i4, j4);
        cmd.wr_src  = MW_RDATA;
      end
      S_F_SW_W2: begin
        cmd.mem_wr  = 1'b1;
        cmd.wr_addr = maddr(stat.piv_row, j4);
        cmd.wr_src  = MW_TMP;
      end
      S_F_PV_RD: begin
        cmd.mem_rd  = 1'b1;
        cmd.rd_addr = maddr(i4, i4);
      end
      S_F_PV_LD: cmd.piv_ld = 1'b1;
      S_F_L_RD: begin
        cmd.mem_rd  = 1'b1;
        cmd.rd_addr = maddr(j4, i4);
      end
      S_F_L_DIV: cmd.div_start = 1'b1;
      S_F_L_WAIT: begin
        if (stat.div_done) begin
          cmd.mem_wr  = 1'b1;
          cmd.wr_addr = maddr(j4, i4);
          cmd.wr_src  = MW_QUOT;
          cmd.lval_ld = 1'b1;
        end
      end
      S_F_K_RDU: begin
        cmd.mem_rd  = 1'b1;
        cmd.rd_addr = maddr(i4, k4);
      end
      S_F_K_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mem_rd  = 1'b1;
        cmd.rd_addr = maddr(j4, k4);
      end
      S_F_K_RND: cmd.rnd_en = 1'b1;
      S_F_K_SUB: begin
        cmd.mem_wr  = 1'b1;
        cmd.wr_addr = maddr(j4, k4);
        cmd.wr_src  = MW_SUB;
      end
      S_F_DONE: begin
        cmd.out_load   = stat.out_free;
        cmd.out_zero   = 1'b1;
        cmd.out_status = stat.sat ? ST_SAT : ST_OK;
        cmd.out_last   = 1'b1;
      end
      S_F_ZERO: begin
        cmd.out_load   = stat.out_free;
        cmd.out_zero   = 1'b1;
        cmd.out_row    = i4;
        cmd.out_status = ST_ZERO_PIVOT;
        cmd.out_last   = 1'b1;
      end
      S_S_ERR: begin
        cmd.out_load   = stat.out_free;
        cmd.out_zero   = 1'b1;
        cmd.out_status = ST_NOT_FACTORED;
        cmd.out_last   = 1'b1;
      end
      S_S_INIT: cmd.sat_clr = 1'b1;
      S_S_WI: begin
        cmd.wv_wr     = 1'b1;
        cmd.wv_wr_idx = i4;
        cmd.wv_src    = WV_INIT;
      end
      S_S_FW_ROW, S_S_BK_ROW: begin
        cmd.acc_ld_wv = 1'b1;
        cmd.wv_idx    = i4;
      end
      S_S_MRD: begin
        cmd.mem_rd  = 1'b1;
        cmd.rd_addr = maddr(i4, j4);
      end
      S_S_MMUL: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_by_wv = 1'b1;
        cmd.wv_idx    = j4;
      end
      S_S_MRND: cmd.rnd_en = 1'b1;
      S_S_MSUB: begin
        cmd.acc_ld_sub   = 1'b1;
        cmd.sub_from_acc = 1'b1;
      end
      S_S_FW_ST: begin
        cmd.wv_wr     = 1'b1;
        cmd.wv_wr_idx = i4;
        cmd.wv_src    = WV_ACC;
      end
      S_S_BK_DRD: begin
        cmd.mem_rd  = 1'b1;
        cmd.rd_addr = maddr(i4, i4);
      end
      S_S_BK_DIV: begin
        cmd.div_start   = 1'b1;
        cmd.div_num_acc = 1'b1;
        cmd.div_den_rd  = 1'b1;
      end
      S_S_BK_WAIT: begin
        if (stat.div_done) begin
          cmd.wv_wr     = 1'b1;
          cmd.wv_wr_idx = i4;
          cmd.wv_src    = WV_QUOT;
        end
      end
      S_S_EMIT: begin
        cmd.out_load   = stat.out_free;
        cmd.wv_idx     = i4;
        cmd.out_row    = i4;
        cmd.out_status = stat.sat ? ST_SAT : ST_OK;
        cmd.out_last   = (i1 == n_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      n_r        <= CNT_W'(MAX_ORDER);
      factored_r <= 1'b0;
      unit_r     <= 1'b0;
      back_r     <= 1'b0;
      i_r        <= '0;
      j_r        <= '0;
      k_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      n_r        <= n_nxt;
      factored_r <= factored_nxt;
      unit_r     <= unit_nxt;
      back_r     <= back_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      k_r        <= k_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/lu_factor_and_solve.sv]
// Loads (matrix or rhs element) are accepted back to back while the block is idle.
// Factor: each multiply-subtract update reads, multiplies, rounds and subtracts;
//   each quotient uses a serial radix-2 divider (48 steps); one result follows.
// Solve: products, diagonal divides, then n results, one per cycle when not stalled.
// Synchronous active-low reset: idle, order n = 16, no valid factorization.
`timescale 1ns / 1ps
`default_nettype none
module lu_factor_and_solve
  import lufs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               in_func,
  input  wire logic [IDX_W-1:0]         in_row,
  input  wire logic [IDX_W-1:0]         in_col,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_value,
  output logic [IDX_W-1:0]              out_row,
  output logic [1:0]                    out_status,
  output logic                          out_last,
  input  wire logic                     cfg_wr_en,
  input  wire logic [4:0]               cfg_wr_data
);

  cmd_t  cmd;
  stat_t stat;

  lufs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stat        (stat),
    .cmd         (cmd)
  );

  lufs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_row     (in_row),
    .in_col     (in_col),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_row    (out_row),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule
`default_nettype wire
